// ----- design/dda_pkg.sv -----
// Package for the DDA line rasterizer: field widths, operation codes and
// parameter defaults. It depends on nothing; the top level takes names from
// it by scope.
package dda_pkg;

   // Widths of the fields on the channels, fixed by the word formats.
   localparam int COORD_W    = 12;
   localparam int STEP_W     = 13;
   localparam int ROW_W      = 15;
   localparam int IDX_W      = 27;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Reset value of the row width register.
   localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 15'd1024;

   // Default values of the top level parameters.
   localparam int SCALE_DEF         = 4;
   localparam int ORIGIN_OFFSET_DEF = 10;
   localparam int FRAC_BITS_DEF     = 16;

   // Operation codes carried in req_tuser.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

endpackage

// ----- design/dda_line_rasterizer_top.sv -----
// DDA line rasterizer, top level: sequencer, shared restoring divider and
// pixel stepping logic. It depends on dda_pkg for widths, codes and defaults.
//
// Use of the block:
// A load word on the req channel (req_tuser = 0) carries two endpoints. The
// line starts at the second endpoint plus ORIGIN_OFFSET and runs towards the
// first. A load gives no rsp word. Each step word (req_tuser = 1) then gives
// one rsp word: the row-major pixel index in rsp_tdata, the write enable in
// rsp_tuser and the last pixel flag in rsp_tlast. A step word with no line
// loaded is taken and dropped. The csr channel writes the row width.
// Timing: a load is accepted, then one shared divider works
// out the x and then the y increment at one quotient bit per cycle, and
// req_tready stays low until both are done, unless the line has zero
// length. A step is accepted, then forms the pixel coordinates and advances
// the position, then forms the index and loads the output register; the
// next step word is accepted only once that register has been loaded.
// The output register lets a new word be accepted while a result still
// waits; while rsp_tready stays low the next pixel waits in the sequencer.
// A synchronous reset drops any line in progress, empties the output
// register and sets the row width back to 1024.
module dda_line_rasterizer_top #(
   parameter int SCALE         = dda_pkg::SCALE_DEF,
   parameter int ORIGIN_OFFSET = dda_pkg::ORIGIN_OFFSET_DEF,
   parameter int FRAC_BITS     = dda_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // from_x [11:0], from_y [23:12], to_x [35:24], to_y [47:36]
   input  logic [dda_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pixel_index [26:0], zero fill [31:27]
   output logic [dda_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // write_enable [0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dda_pkg::ROW_W-1:0]       csr_data
);

   localparam int CW      = dda_pkg::COORD_W;
   localparam int SW      = dda_pkg::STEP_W;
   localparam int POS_W   = FRAC_BITS + 16;
   localparam int NUM_W   = CW + FRAC_BITS + 1;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam int SCALE_W = $clog2(SCALE + 1);
   localparam int SC_W    = POS_W + SCALE_W;
   localparam int PIX_W   = SC_W - FRAC_BITS;
   localparam int PROD_W  = PIX_W + dda_pkg::ROW_W;
   localparam int SUM_W   = ((PROD_W > dda_pkg::IDX_W) ? PROD_W : dda_pkg::IDX_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_PIX  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [POS_W-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [POS_W-1:0]    inc_x_ff, inc_x_in, inc_y_ff, inc_y_in;
   logic [SW-1:0]              steps_left_ff, steps_left_in;
   logic                       line_active_ff, line_active_in;
   logic [CW-1:0]              mag_y_ff, mag_y_in;
   logic                       neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic                       axis_ff, axis_in;
   logic [NUM_W-1:0]           num_ff, num_in;
   logic [SW-1:0]              rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [PIX_W-1:0]           px_ff, px_in, py_ff, py_in;
   logic                       we_ff, we_in, last_ff, last_in;
   logic [dda_pkg::ROW_W-1:0]  row_width_ff, row_width_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dda_pkg::IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                       rsp_we_ff, rsp_we_in, rsp_last_ff, rsp_last_in;

   logic signed [CW-1:0]       from_x, from_y, to_x, to_y;
   logic signed [CW:0]         dx, dy, start_x, start_y;
   logic [CW:0]                ax_full, ay_full;
   logic [CW-1:0]              ax, ay, steps;
   logic [SW:0]                rem_sh;
   logic                       div_ge;
   logic [SW:0]                rem_diff;
   logic [NUM_W-1:0]           num_nx;
   logic [POS_W-1:0]           quot;
   logic [PROD_W-1:0]          idx_prod;
   logic [SUM_W-1:0]           idx_sum;
   logic [dda_pkg::IDX_W-1:0]  idx_val;
   logic                       req_fire;

   // Dividend of one increment: magnitude in fixed point plus half the
   // divisor, so that the quotient comes out rounded to nearest.
   function automatic logic [NUM_W-1:0] div_load(input logic [CW-1:0] m,
                                                  input logic [CW-1:0] s);
      return (NUM_W'(m) << FRAC_BITS) + NUM_W'(s >> 1);
   endfunction

   // Pixel coordinate of a positive position: scale and round half up.
   function automatic logic [PIX_W-1:0] to_pixel(input logic signed [POS_W-1:0] p);
      logic [SC_W-1:0] scaled;
      logic [SC_W-1:0] rounded;
      scaled  = SC_W'($unsigned(p)) * SC_W'(SCALE);
      rounded = scaled + (SC_W'(1) << (FRAC_BITS - 1));
      return rounded[SC_W-1:FRAC_BITS];
   endfunction

   // Apply the sign of the difference to the rounded magnitude.
   function automatic logic signed [POS_W-1:0] signed_inc(input logic [POS_W-1:0] q,
                                                          input logic neg);
      return $signed(neg ? (~q + POS_W'(1)) : q);
   endfunction

   // Unpack the request word and work out differences and the step count.
   always_comb begin
      from_x  = $signed(req_tdata[CW-1:0]);
      from_y  = $signed(req_tdata[2*CW-1:CW]);
      to_x    = $signed(req_tdata[3*CW-1:2*CW]);
      to_y    = $signed(req_tdata[4*CW-1:3*CW]);
      dx      = (CW+1)'(from_x) - (CW+1)'(to_x);
      dy      = (CW+1)'(from_y) - (CW+1)'(to_y);
      ax_full = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
      ay_full = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
      ax      = ax_full[CW-1:0];
      ay      = ay_full[CW-1:0];
      steps   = (ax > ay) ? ax : ay;
      start_x = (CW+1)'(to_x) + $signed({1'b0, CW'(ORIGIN_OFFSET)});
      start_y = (CW+1)'(to_y) + $signed({1'b0, CW'(ORIGIN_OFFSET)});
   end

   // One restoring division step: shift in a dividend bit, trial subtract.
   always_comb begin
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      div_ge   = rem_sh >= {1'b0, steps_left_ff};
      rem_diff = div_ge ? (rem_sh - {1'b0, steps_left_ff}) : rem_sh;
      num_nx   = {num_ff[NUM_W-2:0], div_ge};
      quot     = POS_W'(num_nx);
   end

   // Row-major index of the registered pixel coordinates.
   always_comb begin
      idx_prod = PROD_W'(py_ff) * PROD_W'(row_width_ff);
      idx_sum  = SUM_W'(px_ff) + SUM_W'(idx_prod);
      idx_val  = we_ff ? idx_sum[dda_pkg::IDX_W-1:0] : '0;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Sequencer and datapath next values.
   always_comb begin
      state_in       = state_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      inc_x_in       = inc_x_ff;
      inc_y_in       = inc_y_ff;
      steps_left_in  = steps_left_ff;
      line_active_in = line_active_ff;
      mag_y_in       = mag_y_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      axis_in        = axis_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      we_in          = we_ff;
      last_in        = last_ff;
      row_width_in   = (csr_valid && csr_ready) ? csr_data : row_width_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_index_in   = rsp_index_ff;
      rsp_we_in      = rsp_we_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == dda_pkg::OP_LOAD)) begin
               pos_x_in       = POS_W'(start_x) <<< FRAC_BITS;
               pos_y_in       = POS_W'(start_y) <<< FRAC_BITS;
               steps_left_in  = SW'(steps);
               line_active_in = 1'b1;
               neg_x_in       = dx[CW];
               neg_y_in       = dy[CW];
               mag_y_in       = ay;
               if (steps == '0) begin
                  inc_x_in = '0;
                  inc_y_in = '0;
               end else begin
                  num_in   = div_load(ax, steps);
                  rem_in   = '0;
                  cnt_in   = CNT_W'(NUM_W - 1);
                  axis_in  = 1'b0;
                  state_in = S_DIV;
               end
            end else if (req_fire && line_active_ff) begin
               state_in = S_PIX;
            end
         end
         S_DIV: begin
            num_in = num_nx;
            rem_in = rem_diff[SW-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (!axis_ff) begin
                  inc_x_in = signed_inc(quot, neg_x_ff);
                  num_in   = div_load(mag_y_ff, steps_left_ff[CW-1:0]);
                  rem_in   = '0;
                  cnt_in   = CNT_W'(NUM_W - 1);
                  axis_in  = 1'b1;
               end else begin
                  inc_y_in = signed_inc(quot, neg_y_ff);
                  state_in = S_IDLE;
               end
            end
         end
         S_PIX: begin
            we_in   = (pos_x_ff > 0) && (pos_y_ff > 0);
            px_in   = to_pixel(pos_x_ff);
            py_in   = to_pixel(pos_y_ff);
            last_in = (steps_left_ff == '0);
            if (steps_left_ff == '0) begin
               line_active_in = 1'b0;
            end else begin
               pos_x_in      = pos_x_ff + inc_x_ff;
               pos_y_in      = pos_y_ff + inc_y_ff;
               steps_left_in = steps_left_ff - SW'(1);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_val;
               rsp_we_in    = we_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         row_width_ff   <= dda_pkg::ROW_WIDTH_RESET;
         steps_left_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         row_width_ff   <= row_width_in;
         steps_left_ff  <= steps_left_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      inc_x_ff     <= inc_x_in;
      inc_y_ff     <= inc_y_in;
      mag_y_ff     <= mag_y_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      axis_ff      <= axis_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      we_ff        <= we_in;
      last_ff      <= last_in;
      rsp_index_ff <= rsp_index_in;
      rsp_we_ff    <= rsp_we_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Output word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dda_pkg::RSP_DATA_W'(rsp_index_ff);
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The divider never runs with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (steps_left_ff != '0))
      else $error("divider running with a zero step count");

   // A step word taken while a line is loaded starts a pixel.
   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == dda_pkg::OP_STEP) && line_active_ff)
      |=> (state_ff == S_PIX))
      else $error("step word did not start a pixel");

   // A line ends only on its last pixel.
   a_line_end: assert property (@(posedge clock) disable iff (reset)
      ($fell(line_active_ff) && !$past(reset)) |-> $past(state_ff == S_PIX))
      else $error("line dropped outside a pixel step");

   // The output register fills only from the index stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> $past(state_ff == S_OUT))
      else $error("result word appeared without a pixel");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the DDA line rasterizer: a directed opening,
// then random lines under several row widths. It needs dda_pkg and
// dda_line_rasterizer_top, and nothing else.
module tb_top;

   localparam int FRAC       = dda_pkg::FRAC_BITS_DEF;
   localparam int PIX_SCALE  = dda_pkg::SCALE_DEF;
   localparam int OFFSET     = dda_pkg::ORIGIN_OFFSET_DEF;
   // A load keeps the divider busy for two passes of FRAC + 13 bits.
   localparam int LOAD_CYCLES = 2 * (FRAC + 13) + 10;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [dda_pkg::IDX_W-1:0] index;
      logic                      we;
      logic                      last;
   } pixel_type;

   // Tracks the line being drawn and keeps the pixels still owed by the block.
   class pixel_scoreboard;
      pixel_type pending_pixels[$];
      longint  row_width = longint'(dda_pkg::ROW_WIDTH_RESET);
      longint  pos_x, pos_y, inc_x, inc_y;
      logic [dda_pkg::STEP_W-1:0] steps_left;
      bit      line_active;
      int      words_used;
      int      errors;

      // Fixed-point increment, rounded to nearest on the magnitude.
      function longint step_increment(longint d, longint steps);
         longint q;
         q = (((d < 0 ? -d : d) << FRAC) + steps / 2) / steps;
         return d < 0 ? -q : q;
      endfunction

      // Scaled coordinate, rounded half up; only called for positive p.
      function longint pixel_coord(longint p);
         return (p * PIX_SCALE + (longint'(1) << (FRAC - 1))) >>> FRAC;
      endfunction

      // Called for every accepted request word.
      function void note_word(logic op, logic [dda_pkg::REQ_DATA_W-1:0] d);
         longint fx, fy, tx, ty, dx, dy, ax, ay, steps;
         pixel_type px;
         if (op == dda_pkg::OP_LOAD) begin
            fx = longint'($signed(d[11:0]));
            fy = longint'($signed(d[23:12]));
            tx = longint'($signed(d[35:24]));
            ty = longint'($signed(d[47:36]));
            dx = fx - tx;
            dy = fy - ty;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            steps = ax > ay ? ax : ay;
            pos_x = (tx + OFFSET) << FRAC;
            pos_y = (ty + OFFSET) << FRAC;
            inc_x = steps == 0 ? 0 : step_increment(dx, steps);
            inc_y = steps == 0 ? 0 : step_increment(dy, steps);
            steps_left = steps[dda_pkg::STEP_W-1:0];
            line_active = 1'b1;
            words_used++;
         end else if (line_active) begin
            px.we = pos_x > 0 && pos_y > 0;
            px.last = steps_left == 0;
            px.index = '0;
            if (px.we) begin
               px.index = dda_pkg::IDX_W'(pixel_coord(pos_x) +
                                          pixel_coord(pos_y) * row_width);
            end
            pending_pixels.push_back(px);
            words_used++;
            if (px.last) begin
               line_active = 1'b0;
            end else begin
               pos_x += inc_x;
               pos_y += inc_y;
               steps_left = steps_left - 1'b1;
            end
         end
      endfunction

      // Called for every accepted response word.
      function void check_pixel(logic [dda_pkg::RSP_DATA_W-1:0] data, logic we,
                                logic last);
         pixel_type px;
         if (pending_pixels.size() == 0) begin
            $error("unexpected rsp word: tdata %h tuser %b tlast %b", data, we, last);
            errors++;
            return;
         end
         px = pending_pixels.pop_front();
         if (data !== {{(dda_pkg::RSP_DATA_W - dda_pkg::IDX_W){1'b0}}, px.index}) begin
            $error("pixel_index: expected %0d, got %0d", px.index, data);
            errors++;
         end
         if (we !== px.we) begin
            $error("write_enable: expected %b, got %b", px.we, we);
            errors++;
         end
         if (last !== px.last) begin
            $error("last_pixel: expected %b, got %b", px.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [dda_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [dda_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tuser;
   logic                             rsp_tlast;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [dda_pkg::ROW_W-1:0]        csr_data;

   pixel_scoreboard sb;
   int  gap_max;
   int  stall_max;
   bit  hold_request;
   int  cycle_count;

   dda_line_rasterizer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Packs the two endpoints into a request word, from_x in the lowest bits.
   function automatic logic [dda_pkg::REQ_DATA_W-1:0] endpoints(int fx, int fy,
                                                               int tx, int ty);
      return {ty[11:0], tx[11:0], fy[11:0], fx[11:0]};
   endfunction

   function automatic int clamp_coord(int v);
      return v > 2047 ? 2047 : (v < -2048 ? -2048 : v);
   endfunction

   // Offers one word after a random gap and waits until it is taken.
   task automatic send_word(logic op, logic [dda_pkg::REQ_DATA_W-1:0] data);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_word(op, data);
   endtask

   task automatic send_steps(int count);
      repeat (count) send_word(dda_pkg::OP_STEP, dda_pkg::REQ_DATA_W'({$urandom, $urandom}));
   endtask

   // Writes the row width once the block has drained and the divider is idle.
   task automatic write_row_width(int value);
      req_tvalid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (LOAD_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= dda_pkg::ROW_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.row_width = value;
   endtask

   // One line with random endpoints; mostly drawn to its end, sometimes cut
   // short by the next load or followed by steps that find no line.
   task automatic random_line();
      int tx, ty, fx, fy, span, pick, count, ax, ay;
      pick = $urandom_range(0, 99);
      span = pick < 80 ? 16 : (pick < 95 ? 100 : 400);
      if ($urandom_range(0, 1)) begin
         tx = int'($urandom_range(0, 4095)) - 2048;
         ty = int'($urandom_range(0, 4095)) - 2048;
      end else begin
         tx = $urandom_range(0, 2047);
         ty = $urandom_range(0, 2047);
      end
      fx = clamp_coord(tx + int'($urandom_range(0, 2 * span)) - span);
      fy = clamp_coord(ty + int'($urandom_range(0, 2 * span)) - span);
      ax = fx > tx ? fx - tx : tx - fx;
      ay = fy > ty ? fy - ty : ty - fy;
      count = (ax > ay ? ax : ay) + 1;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         count = $urandom_range(0, count - 1);
      end else if (pick < 20) begin
         count = count + int'($urandom_range(1, 3));
      end
      gap_max   = $urandom_range(0, 7) == 0 ? 0 : 9;
      stall_max = $urandom_range(0, 7) == 0 ? 0 : 9;
      send_word(dda_pkg::OP_LOAD, endpoints(fx, fy, tx, ty));
      send_steps(count);
   endtask

   // Response side: random stall per word, and one long hold-off on request.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      stall = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            sb.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
            stall = $urandom_range(0, stall_max);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall = 0;
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus.
   initial begin
      int phase_width[5];
      int phase_goal;
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = dda_pkg::OP_LOAD;
      csr_valid  = 1'b0;
      csr_data   = '0;
      cycle_count  = 0;
      hold_request = 1'b0;
      gap_max   = 9;
      stall_max = 9;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening, at the reset row width.
      // A step with no line loaded is dropped.
      send_steps(1);
      // Zero-length line: one pixel, flagged last; the extra step is dropped.
      send_word(dda_pkg::OP_LOAD, endpoints(5, 7, 5, 7));
      send_steps(2);
      // Longest possible line, starting far off screen, cut short.
      send_word(dda_pkg::OP_LOAD, endpoints(2047, 2047, -2048, -2048));
      send_steps(3);
      // Opposite corners, negative x direction.
      send_word(dda_pkg::OP_LOAD, endpoints(-2048, 2047, 2047, -2048));
      send_steps(2);
      // Starts exactly at zero, so the first pixel is not written.
      send_word(dda_pkg::OP_LOAD, endpoints(-7, -7, -10, -10));
      send_steps(4);
      // Increment of a third needs rounding.
      send_word(dda_pkg::OP_LOAD, endpoints(3, -1, 0, 0));
      send_steps(4);
      // A row width of 16384 at the far corner: the index wraps.
      write_row_width(16384);
      send_word(dda_pkg::OP_LOAD, endpoints(2047, 2047, 2047, 2047));
      send_steps(1);

      // Random phases, each under its own row width.
      phase_width[0] = 1;
      phase_width[1] = 16384;
      phase_width[2] = $urandom_range(1, 16384);
      phase_width[3] = 1024;
      phase_width[4] = $urandom_range(1, 2048);
      for (int phase = 0; phase < 5; phase++) begin
         write_row_width(phase_width[phase]);
         if (phase == 2) begin
            // Long receiver hold-off while the sender keeps offering words.
            gap_max = 0;
            hold_request = 1'b1;
            send_word(dda_pkg::OP_LOAD, endpoints(160, 130, 100, 100));
            send_steps(61);
         end
         phase_goal = sb.words_used + 300;
         while (sb.words_used < phase_goal) random_line();
      end

      // Drain, then allow for stray words.
      req_tvalid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (LOAD_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/dda_pkg.sv
design/dda_line_rasterizer_top.sv
dv/tb_top.sv
